>>> design/ted_pkg.sv
`default_nettype none
package ted_pkg;

    localparam int unsigned WindowWidth = 16;
    localparam logic [WindowWidth-1:0] WindowReset = 16'd1024;
    localparam logic [WindowWidth-1:0] PosMax = '1;

    typedef enum logic [2:0] {
        CODE_SJIS    = 3'd0,
        CODE_EUC     = 3'd1,
        CODE_UTF8    = 3'd2,
        CODE_UTF16LE = 3'd3,
        CODE_UTF16BE = 3'd4
    } t_code;

    typedef struct packed {
        logic utf8_ok;
        logic sjis_ok;
        logic euc_ok;
    } t_verdict;

    typedef enum logic [1:0] {
        EUC_KIND_FULL = 2'd0,
        EUC_KIND_KANA = 2'd1,
        EUC_KIND_EXT  = 2'd2
    } t_euc_kind;

endpackage
`default_nettype wire

>>> design/text_encoding_detector.sv
`default_nettype none
// Classifies one text, fed one byte per request with tlast on its final byte, as
// Shift-JIS, EUC-JP, UTF-8, UTF-16LE or UTF-16BE. A byte order mark in the first
// bytes decides outright (tuser = 1); otherwise UTF-8, Shift-JIS and EUC-JP
// validators, which start characters only in the first window_bytes bytes, pick
// the code. One result follows each last byte, in the cycle after it is taken.
// A byte is taken every cycle unless a result waits unaccepted: all validator and
// mark logic sits between the accepted byte and the result register.
module text_encoding_detector
    import ted_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [WindowWidth-1:0] i_cfg_data,   // window_bytes
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [7:0]             i_s_tdata,    // data_byte
    input  wire logic                   i_s_tlast,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [7:0]                  o_m_tdata,    // code[2:0], zero fill
    output logic                        o_m_tuser     // from_mark
);

    logic [WindowWidth-1:0] r_window;
    logic [WindowWidth-1:0] r_pos, n_pos;
    logic [23:0]            r_head, n_head;
    logic                   r_out_valid;
    t_code                  r_code, n_code;
    logic                   r_mark, n_mark;
    logic                   acc;
    t_verdict               verdict;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign acc         = i_s_tvalid && o_s_tready;

    ted_validate u_validate (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (acc),
        .i_last    (i_s_tlast),
        .i_start   (r_pos < r_window),
        .i_byte    (i_s_tdata),
        .o_verdict (verdict)
    );

    always_comb begin
        n_head = r_head;
        case (r_pos)
            16'd0:   n_head[7:0]   = i_s_tdata;
            16'd1:   n_head[15:8]  = i_s_tdata;
            16'd2:   n_head[23:16] = i_s_tdata;
            default: n_head = r_head;
        endcase
        n_pos = (r_pos == PosMax) ? r_pos : r_pos + 16'd1;
    end

    always_comb begin
        n_mark = 1'b1;
        if (n_pos >= 16'd2 && n_head[7:0] == 8'hff && n_head[15:8] == 8'hfe) begin
            n_code = CODE_UTF16LE;
        end else if (n_pos >= 16'd2 && n_head[7:0] == 8'hfe && n_head[15:8] == 8'hff) begin
            n_code = CODE_UTF16BE;
        end else if (n_pos >= 16'd3 && n_head == 24'hbfbbef) begin
            n_code = CODE_UTF8;
        end else begin
            n_mark = 1'b0;
            if (verdict.utf8_ok) n_code = CODE_UTF8;
            else if (!verdict.sjis_ok && !verdict.euc_ok) n_code = CODE_UTF16LE;
            else if (verdict.sjis_ok && !verdict.euc_ok) n_code = CODE_SJIS;
            else n_code = CODE_EUC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WindowReset;
        end else if (i_cfg_valid) begin
            r_window <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_pos  <= i_s_tlast ? '0 : n_pos;
                r_head <= i_s_tlast ? '0 : n_head;
            end
            if (acc && i_s_tlast) r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_s_tlast) begin
            r_code <= n_code;
            r_mark <= n_mark;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_code};
    assign o_m_tuser  = r_mark;

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(acc && i_s_tlast))
        else $error("result without a last byte");

    a_text_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_s_tlast |=> r_pos == '0 && r_head == '0)
        else $error("text state not cleared after last byte");

    a_mark_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> r_code == CODE_UTF8 || r_code == CODE_UTF16LE
            || r_code == CODE_UTF16BE)
        else $error("byte order mark with a non-Unicode code");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !acc)
        else $error("byte taken while result is stalled");

endmodule
`default_nettype wire

>>> design/ted_validate.sv
`default_nettype none
module ted_validate
    import ted_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_last,
    input  wire logic       i_start,
    input  wire logic [7:0] i_byte,
    output t_verdict        o_verdict
);

    logic [2:0] r_u_pend, n_u_pend;
    logic       r_u_ok, n_u_ok;
    logic       r_s_pend, n_s_pend;
    logic       r_s_ok, n_s_ok;
    logic [1:0] r_e_pend, n_e_pend;
    t_euc_kind  r_e_kind, n_e_kind;
    logic       r_e_ok, n_e_ok;

    always_comb begin
        n_u_pend = r_u_pend;
        n_u_ok   = r_u_ok;
        if (r_u_ok) begin
            if (r_u_pend != 3'd0) begin
                if (!(i_byte inside {[8'h80:8'hbf]})) n_u_ok = 1'b0;
                n_u_pend = r_u_pend - 3'd1;
            end else if (i_start && i_byte[7]) begin
                if (i_byte <= 8'hc1 || i_byte >= 8'hfe) n_u_ok = 1'b0;
                else if (i_byte >= 8'hfc) n_u_pend = 3'd5;
                else if (i_byte >= 8'hf8) n_u_pend = 3'd4;
                else if (i_byte >= 8'hf0) n_u_pend = 3'd3;
                else if (i_byte >= 8'he0) n_u_pend = 3'd2;
                else n_u_pend = 3'd1;
            end
        end
    end

    always_comb begin
        n_s_pend = r_s_pend;
        n_s_ok   = r_s_ok;
        if (r_s_ok) begin
            if (r_s_pend) begin
                if (!(i_byte inside {[8'h40:8'h7e], [8'h80:8'hfc]})) n_s_ok = 1'b0;
                n_s_pend = 1'b0;
            end else if (i_start) begin
                if (i_byte inside {[8'h81:8'h9f], [8'he0:8'hfc]}) n_s_pend = 1'b1;
                else if (!(i_byte < 8'h80 || i_byte inside {[8'ha1:8'hdf]})) n_s_ok = 1'b0;
            end
        end
    end

    always_comb begin
        n_e_pend = r_e_pend;
        n_e_kind = r_e_kind;
        n_e_ok   = r_e_ok;
        if (r_e_ok) begin
            if (r_e_pend != 2'd0) begin
                if (r_e_kind == EUC_KIND_KANA) begin
                    if (!(i_byte inside {[8'ha1:8'hdf]})) n_e_ok = 1'b0;
                end else begin
                    if (!(i_byte inside {[8'ha1:8'hfe]})) n_e_ok = 1'b0;
                end
                n_e_pend = r_e_pend - 2'd1;
            end else if (i_start && i_byte[7]) begin
                if (i_byte inside {[8'ha1:8'hfe]}) begin
                    n_e_pend = 2'd1;
                    n_e_kind = EUC_KIND_FULL;
                end else if (i_byte == 8'h8e) begin
                    n_e_pend = 2'd1;
                    n_e_kind = EUC_KIND_KANA;
                end else if (i_byte == 8'h8f) begin
                    n_e_pend = 2'd2;
                    n_e_kind = EUC_KIND_EXT;
                end else begin
                    n_e_ok = 1'b0;
                end
            end
        end
    end

    assign o_verdict.utf8_ok = n_u_ok && (n_u_pend == 3'd0);
    assign o_verdict.sjis_ok = n_s_ok && !n_s_pend;
    assign o_verdict.euc_ok  = n_e_ok && (n_e_pend == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_u_pend <= '0;
            r_u_ok   <= 1'b1;
            r_s_pend <= 1'b0;
            r_s_ok   <= 1'b1;
            r_e_pend <= '0;
            r_e_kind <= EUC_KIND_FULL;
            r_e_ok   <= 1'b1;
        end else if (i_en) begin
            r_u_pend <= n_u_pend;
            r_u_ok   <= n_u_ok;
            r_s_pend <= n_s_pend;
            r_s_ok   <= n_s_ok;
            r_e_pend <= n_e_pend;
            r_e_kind <= n_e_kind;
            r_e_ok   <= n_e_ok;
        end
    end

endmodule
`default_nettype wire

>>> bench/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ted_pkg::*;

    typedef struct packed {
        t_code code;
        logic  from_mark;
    } t_detect;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [15:0]      i_cfg_data  = '0;
    logic             i_s_tvalid  = 1'b0;
    logic             o_s_tready;
    logic [7:0]       i_s_tdata   = '0;
    logic             i_s_tlast   = 1'b0;
    logic             o_m_tvalid;
    logic             i_m_tready  = 1'b0;
    logic [7:0]       o_m_tdata;
    logic             o_m_tuser;

    text_encoding_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    logic [15:0] window_reg;
    logic [15:0] txt_pos;
    logic [7:0]  head [3];
    logic [2:0]  u8_left;
    logic        u8_valid;
    logic        sj_left;
    logic        sj_valid;
    logic [1:0]  eu_left;
    t_euc_kind   eu_kind;
    logic        eu_valid;

    t_detect     encoding_q [$];
    logic [7:0]  text_q [$];

    int gap_pct   = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int n_checked  = 0;
    int n_bytes    = 0;
    int n_texts    = 0;
    int n_writes   = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAIL text_encoding_detector");
        $finish;
    end

    function automatic void clear_text();
        txt_pos  = '0;
        head[0]  = '0;
        head[1]  = '0;
        head[2]  = '0;
        u8_left  = '0;
        u8_valid = 1'b1;
        sj_left  = 1'b0;
        sj_valid = 1'b1;
        eu_left  = '0;
        eu_kind  = EUC_KIND_FULL;
        eu_valid = 1'b1;
    endfunction

    function automatic void track_byte(input logic [7:0] b, input logic lst);
        logic    start;
        t_detect res;
        start = (txt_pos < window_reg);
        if (txt_pos < 3) head[txt_pos[1:0]] = b;

        if (u8_valid) begin
            if (u8_left != 0) begin
                if (b < 8'h80 || b > 8'hbf) u8_valid = 1'b0;
                u8_left = u8_left - 3'd1;
            end else if (start && b >= 8'h80) begin
                if (b <= 8'hc1 || b >= 8'hfe) u8_valid = 1'b0;
                else if (b >= 8'hfc) u8_left = 3'd5;
                else if (b >= 8'hf8) u8_left = 3'd4;
                else if (b >= 8'hf0) u8_left = 3'd3;
                else if (b >= 8'he0) u8_left = 3'd2;
                else u8_left = 3'd1;
            end
        end

        if (sj_valid) begin
            if (sj_left) begin
                if (!((b >= 8'h40 && b <= 8'h7e) || (b >= 8'h80 && b <= 8'hfc)))
                    sj_valid = 1'b0;
                sj_left = 1'b0;
            end else if (start && b >= 8'h80 && !(b >= 8'ha1 && b <= 8'hdf)) begin
                if ((b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc)) sj_left = 1'b1;
                else sj_valid = 1'b0;
            end
        end

        if (eu_valid) begin
            if (eu_left != 0) begin
                if (b < 8'ha1 || b > ((eu_kind == EUC_KIND_KANA) ? 8'hdf : 8'hfe))
                    eu_valid = 1'b0;
                eu_left = eu_left - 2'd1;
            end else if (start && b >= 8'h80) begin
                if (b >= 8'ha1 && b <= 8'hfe) begin
                    eu_left = 2'd1;
                    eu_kind = EUC_KIND_FULL;
                end else if (b == 8'h8e) begin
                    eu_left = 2'd1;
                    eu_kind = EUC_KIND_KANA;
                end else if (b == 8'h8f) begin
                    eu_left = 2'd2;
                    eu_kind = EUC_KIND_EXT;
                end else begin
                    eu_valid = 1'b0;
                end
            end
        end

        if (txt_pos != PosMax) txt_pos = txt_pos + 16'd1;

        if (lst) begin
            if (u8_left != 0) u8_valid = 1'b0;
            if (sj_left) sj_valid = 1'b0;
            if (eu_left != 0) eu_valid = 1'b0;
            res.from_mark = 1'b1;
            if (txt_pos >= 2 && head[0] == 8'hff && head[1] == 8'hfe)
                res.code = CODE_UTF16LE;
            else if (txt_pos >= 2 && head[0] == 8'hfe && head[1] == 8'hff)
                res.code = CODE_UTF16BE;
            else if (txt_pos >= 3 && head[0] == 8'hef && head[1] == 8'hbb && head[2] == 8'hbf)
                res.code = CODE_UTF8;
            else begin
                res.from_mark = 1'b0;
                if (u8_valid) res.code = CODE_UTF8;
                else if (!sj_valid && !eu_valid) res.code = CODE_UTF16LE;
                else if (sj_valid && !eu_valid) res.code = CODE_SJIS;
                else res.code = CODE_EUC;
            end
            encoding_q.push_back(res);
            n_texts++;
            clear_text();
        end
    endfunction

    always @(posedge i_clk) begin
        t_detect want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (encoding_q.size() == 0) begin
                $error("code: expected none, got %0d", o_m_tdata[2:0]);
                mismatches++;
            end else begin
                want = encoding_q.pop_front();
                n_checked++;
                if (o_m_tdata[2:0] !== want.code) begin
                    $error("code: expected %0d, got %0d", want.code, o_m_tdata[2:0]);
                    mismatches++;
                end
                if (o_m_tdata[7:3] !== 5'd0) begin
                    $error("tdata fill: expected 0, got %0d", o_m_tdata[7:3]);
                    mismatches++;
                end
                if (o_m_tuser !== want.from_mark) begin
                    $error("from_mark: expected %0d, got %0d", want.from_mark, o_m_tuser);
                    mismatches++;
                end
            end
        end
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic lst);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_tready);
        track_byte(b, lst);
        n_bytes++;
        if ($urandom_range(0, 99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < gap_pct);
        end
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (encoding_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [15:0] w);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        window_reg = w;
        n_writes++;
    endtask

    task automatic add_char(input int enc);
        int len;
        case (enc)
            0: begin
                len = $urandom_range(1, 6);
                case (len)
                    1: text_q.push_back(8'($urandom_range(8'h00, 8'h7f)));
                    2: text_q.push_back(8'($urandom_range(8'hc2, 8'hdf)));
                    3: text_q.push_back(8'($urandom_range(8'he0, 8'hef)));
                    4: text_q.push_back(8'($urandom_range(8'hf0, 8'hf7)));
                    5: text_q.push_back(8'($urandom_range(8'hf8, 8'hfb)));
                    default: text_q.push_back(8'($urandom_range(8'hfc, 8'hfd)));
                endcase
                repeat (len - 1) text_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
            end
            1: begin
                case ($urandom_range(0, 2))
                    0: text_q.push_back(8'($urandom_range(8'h00, 8'h7f)));
                    1: text_q.push_back(8'($urandom_range(8'ha1, 8'hdf)));
                    default: begin
                        if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(8'h81, 8'h9f)));
                        else text_q.push_back(8'($urandom_range(8'he0, 8'hfc)));
                        if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(8'h40, 8'h7e)));
                        else text_q.push_back(8'($urandom_range(8'h80, 8'hfc)));
                    end
                endcase
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: text_q.push_back(8'($urandom_range(8'h00, 8'h7f)));
                    1: repeat (2) text_q.push_back(8'($urandom_range(8'ha1, 8'hfe)));
                    2: begin
                        text_q.push_back(8'h8e);
                        text_q.push_back(8'($urandom_range(8'ha1, 8'hdf)));
                    end
                    default: begin
                        text_q.push_back(8'h8f);
                        repeat (2) text_q.push_back(8'($urandom_range(8'ha1, 8'hfe)));
                    end
                endcase
            end
            default: text_q.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic build_text();
        int style;
        int nchar;
        int enc;
        text_q.delete();
        style = $urandom_range(0, 9);
        nchar = $urandom_range(1, 10);
        enc = (style <= 2) ? 0 : (style <= 4) ? 1 : (style <= 6) ? 2 : (style == 8) ? 3
            : $urandom_range(0, 2);
        if (style == 7) begin
            case ($urandom_range(0, 2))
                0: text_q = '{8'hff, 8'hfe};
                1: text_q = '{8'hfe, 8'hff};
                default: text_q = '{8'hef, 8'hbb, 8'hbf};
            endcase
            nchar = $urandom_range(0, 6);
        end
        repeat (nchar) add_char(enc);
        if (style == 9) begin
            if (text_q.size() > 1 && $urandom_range(0, 1)) void'(text_q.pop_back());
            else text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic test_marks();
        text_q = '{8'hff, 8'hfe};
        send_text();
        text_q = '{8'hfe, 8'hff, 8'h00};
        send_text();
        text_q = '{8'hef, 8'hbb, 8'hbf};
        send_text();
        text_q = '{8'hff};
        send_text();
    endtask

    task automatic test_validators();
        text_q = '{8'hc3, 8'hc0};
        send_text();
        text_q = '{8'h8f, 8'ha1, 8'ha0};
        send_text();
        text_q = '{8'h82, 8'ha0, 8'h41};
        send_text();
        text_q = '{8'he3, 8'h81};
        send_text();
        text_q = '{8'hfc, 8'hbf, 8'h80, 8'h80, 8'h80, 8'h80};
        send_text();
        settle();
    endtask

    task automatic test_window_limits();
        write_window(16'd0);
        text_q = '{8'h80, 8'hff};
        send_text();
        text_q = '{8'hff, 8'hfe};
        send_text();
        write_window(16'd1);
        text_q = '{8'h41, 8'hc3};
        send_text();
        write_window(16'd2);
        text_q = '{8'h41, 8'hc3, 8'h28};
        send_text();
        write_window(16'hffff);
        text_q = '{8'hc3};
        send_text();
        settle();
    endtask

    task automatic test_random_phase(input int gap, input int stall, input int target);
        int start_bytes;
        int texts;
        gap_pct   = gap;
        stall_pct = stall;
        start_bytes = n_bytes;
        texts = 0;
        while (n_bytes - start_bytes < target) begin
            if (texts % 25 == 0) begin
                case ($urandom_range(0, 3))
                    0: write_window(16'd1);
                    1: write_window(16'hffff);
                    2: write_window(WindowReset);
                    default: write_window(16'($urandom_range(1, 24)));
                endcase
            end
            build_text();
            send_text();
            texts++;
        end
        settle();
    endtask

    initial begin
        window_reg = WindowReset;
        clear_text();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_marks();
        test_validators();
        test_window_limits();
        test_random_phase(0, 0, 370);
        test_random_phase(67, 0, 370);
        test_random_phase(0, 67, 370);
        test_random_phase(37, 37, 370);

        settle();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d verdicts from %0d texts, %0d bytes, marks and validator edges",
                 n_checked, n_texts, n_bytes);
        $display("Window written %0d times (0, 1, 2, 1024, 65535 and random small values)",
                 n_writes);
        if (mismatches == 0 && encoding_q.size() == 0) begin
            $display("PASS text_encoding_detector");
        end else begin
            $display("FAIL text_encoding_detector");
        end
        $finish;
    end

endmodule
`default_nettype wire
